>>> rtl/core/circle_oriented_rect_overlap_unit_assert.svh
// Assertion macros for the circle / oriented rectangle overlap unit.
`ifndef CIRCLE_ORIENTED_RECT_OVERLAP_UNIT_ASSERT_SVH
`define CIRCLE_ORIENTED_RECT_OVERLAP_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define CORO_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: lbl");

// Check that an antecedent implies a consequent in the same cycle.
`define CORO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> rtl/core/coro_pkg.sv
// ----------------------------------------------------------------------------
// coro_pkg
// Types and constants shared by the circle / oriented rectangle overlap unit.
// ----------------------------------------------------------------------------
package coro_pkg;

    localparam int unsigned CoordW  = 24;
    localparam int unsigned RadiusW = 23;
    localparam int unsigned ExtentW = 24;
    localparam int unsigned RotW    = 16;
    localparam int unsigned RotFrac = 14;

    // Pipeline depth from accepted word to result strobe.
    localparam int unsigned Latency = 6;

    typedef struct packed {
        logic signed [CoordW-1:0]  circle_x;
        logic signed [CoordW-1:0]  circle_y;
        logic        [RadiusW-1:0] circle_radius;
        logic signed [CoordW-1:0]  box_x;
        logic signed [CoordW-1:0]  box_y;
        logic        [ExtentW-1:0] box_width;
        logic        [ExtentW-1:0] box_height;
        logic signed [RotW-1:0]    rot_cos;
        logic signed [RotW-1:0]    rot_sin;
    } t_query;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] local_x;
        logic signed [CoordW-1:0] local_y;
    } t_result;

endpackage

>>> rtl/core/circle_oriented_rect_overlap_unit.sv
// ----------------------------------------------------------------------------
// circle_oriented_rect_overlap_unit
// Pipelined circle versus oriented rectangle overlap test.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a query word on i_query and raise start; the word is taken at the
//   rising edge where start is high and busy is low. busy is low whenever
//   reset is released, so one query per clock is accepted.
//   Every query yields exactly one result word on o_result, shown for one
//   cycle with o_valid high; o_valid is the last bit of a registered valid
//   chain that runs beside the six register stages. Throughput is one
//   query per cycle; the six register stages are difference, rotation
//   products, sum and round, extent compare, squaring, and final region
//   select with the corner compare. The squaring stage holds the widest
//   multipliers.
//   The receiver cannot hold results off and the pipeline never stalls.
//   Synchronous active-low reset clears all valid bits; words in flight are
//   dropped and busy stays high while reset is held.
//   local_x/local_y are the circle centre in the rectangle frame, rounded
//   half up to Q16.8 and saturated; hit uses the unsaturated value.
// ----------------------------------------------------------------------------
`include "circle_oriented_rect_overlap_unit_assert.svh"

module circle_oriented_rect_overlap_unit
    import coro_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_query  i_query,
    output logic    o_valid,
    output t_result o_result
);

    localparam int unsigned DiffW = CoordW + 1;
    localparam int unsigned ProdW = DiffW + RotW;
    localparam int unsigned SumW  = ProdW + 1;
    localparam int unsigned LocW  = SumW - RotFrac;
    localparam int unsigned DblW  = LocW + 1;
    localparam int unsigned SqW   = 2 * DblW;
    localparam int unsigned RrW   = RadiusW + 1;

    localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (RotFrac - 1);
    localparam logic signed [CoordW-1:0] LocMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic signed [CoordW-1:0] LocMin = {1'b1, {(CoordW-1){1'b0}}};

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // valid chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // stage 1: centre difference
    logic signed [DiffW-1:0]   r_dx1, r_dy1;
    logic signed [RotW-1:0]    r_c1, r_s1;
    logic        [RadiusW-1:0] r_rad1;
    logic        [ExtentW-1:0] r_w1, r_h1;

    always_ff @(posedge i_clk) begin
        r_dx1  <= DiffW'(i_query.circle_x) - DiffW'(i_query.box_x);
        r_dy1  <= DiffW'(i_query.circle_y) - DiffW'(i_query.box_y);
        r_c1   <= i_query.rot_cos;
        r_s1   <= i_query.rot_sin;
        r_rad1 <= i_query.circle_radius;
        r_w1   <= i_query.box_width;
        r_h1   <= i_query.box_height;
    end

    // stage 2: rotation products
    logic signed [ProdW-1:0]   r_pxc2, r_pys2, r_pyc2, r_pxs2;
    logic        [RadiusW-1:0] r_rad2;
    logic        [ExtentW-1:0] r_w2, r_h2;

    always_ff @(posedge i_clk) begin
        r_pxc2 <= ProdW'(r_dx1) * ProdW'(r_c1);
        r_pys2 <= ProdW'(r_dy1) * ProdW'(r_s1);
        r_pyc2 <= ProdW'(r_dy1) * ProdW'(r_c1);
        r_pxs2 <= ProdW'(r_dx1) * ProdW'(r_s1);
        r_rad2 <= r_rad1;
        r_w2   <= r_w1;
        r_h2   <= r_h1;
    end

    // stage 3: sum and round half up to Q.8
    logic signed [SumW-1:0]    n_sumx3, n_sumy3;
    logic signed [LocW-1:0]    r_lx3, r_ly3;
    logic        [RadiusW-1:0] r_rad3;
    logic        [ExtentW-1:0] r_w3, r_h3;

    always_comb begin
        n_sumx3 = SumW'(r_pxc2) + SumW'(r_pys2) + RoundHalf;
        n_sumy3 = SumW'(r_pyc2) - SumW'(r_pxs2) + RoundHalf;
    end

    always_ff @(posedge i_clk) begin
        r_lx3  <= n_sumx3[SumW-1:RotFrac];
        r_ly3  <= n_sumy3[SumW-1:RotFrac];
        r_rad3 <= r_rad2;
        r_w3   <= r_w2;
        r_h3   <= r_h2;
    end

    // stage 4: doubled compares against the extents, saturate outputs
    logic [LocW-1:0]    n_ax4, n_ay4;
    logic [DblW-1:0]    n_ax24, n_ay24, n_lim_x4, n_lim_y4;
    logic [RrW-1:0]     n_rr4;
    logic signed [CoordW-1:0] n_satx4, n_saty4;

    logic               r_outx4, r_outy4, r_hx4, r_hy4;
    logic [DblW-1:0]    r_ex4, r_ey4;
    logic [RrW-1:0]     r_rr4;
    logic signed [CoordW-1:0] r_satx4, r_saty4;

    always_comb begin
        n_ax4    = r_lx3[LocW-1] ? LocW'(-r_lx3) : LocW'(r_lx3);
        n_ay4    = r_ly3[LocW-1] ? LocW'(-r_ly3) : LocW'(r_ly3);
        n_ax24   = {n_ax4, 1'b0};
        n_ay24   = {n_ay4, 1'b0};
        n_rr4    = {r_rad3, 1'b0};
        n_lim_x4 = DblW'(r_w3) + DblW'(n_rr4);
        n_lim_y4 = DblW'(r_h3) + DblW'(n_rr4);

        if (r_lx3 > LocW'(LocMax)) begin
            n_satx4 = LocMax;
        end else if (r_lx3 < LocW'(LocMin)) begin
            n_satx4 = LocMin;
        end else begin
            n_satx4 = r_lx3[CoordW-1:0];
        end
        if (r_ly3 > LocW'(LocMax)) begin
            n_saty4 = LocMax;
        end else if (r_ly3 < LocW'(LocMin)) begin
            n_saty4 = LocMin;
        end else begin
            n_saty4 = r_ly3[CoordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_outx4 <= n_ax24 > DblW'(r_w3);
        r_outy4 <= n_ay24 > DblW'(r_h3);
        r_hx4   <= n_ax24 <= n_lim_x4;
        r_hy4   <= n_ay24 <= n_lim_y4;
        r_ex4   <= n_ax24 - DblW'(r_w3);
        r_ey4   <= n_ay24 - DblW'(r_h3);
        r_rr4   <= n_rr4;
        r_satx4 <= n_satx4;
        r_saty4 <= n_saty4;
    end

    // stage 5: squares for the corner test
    logic [SqW-1:0]     r_ex25, r_ey25, r_rr25;
    logic               r_outx5, r_outy5, r_hx5, r_hy5;
    logic signed [CoordW-1:0] r_satx5, r_saty5;

    always_ff @(posedge i_clk) begin
        r_ex25  <= SqW'(r_ex4) * SqW'(r_ex4);
        r_ey25  <= SqW'(r_ey4) * SqW'(r_ey4);
        r_rr25  <= SqW'(r_rr4) * SqW'(r_rr4);
        r_outx5 <= r_outx4;
        r_outy5 <= r_outy4;
        r_hx5   <= r_hx4;
        r_hy5   <= r_hy4;
        r_satx5 <= r_satx4;
        r_saty5 <= r_saty4;
    end

    // stage 6: pick the region rule
    logic           n_hit6;
    logic [SqW:0]   n_dist6;
    t_result        r_res6;

    always_comb begin
        n_dist6 = (SqW+1)'(r_ex25) + (SqW+1)'(r_ey25);
        if (r_outx5 && r_outy5) begin
            n_hit6 = n_dist6 <= (SqW+1)'(r_rr25);
        end else if (r_outx5) begin
            n_hit6 = r_hx5;
        end else if (r_outy5) begin
            n_hit6 = r_hy5;
        end else begin
            n_hit6 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res6.hit     <= n_hit6;
        r_res6.local_x <= r_satx5;
        r_res6.local_y <= r_saty5;
    end

    assign o_valid  = r_v6;
    assign o_result = r_res6;

    `CORO_ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == $past(accept, Latency))
    `CORO_ASSERT_IMP(a_inside_hit, i_clk, i_rst_n, r_v6 && !$past(r_outx4, 2) && !$past(r_outy4, 2), o_result.hit)
    `CORO_ASSERT_IMP(a_no_busy, i_clk, i_rst_n, 1'b1, !busy)

endmodule
